/* design/cmsd_pkg.sv */
// shared types and constants for the camera media stream deframer
`timescale 1ns / 1ps
package cmsd_pkg;
	localparam int unsigned QueueDepth = 4;

	typedef enum logic [1:0] {
		KIND_VIDEO = 2'd0,
		KIND_AUDIO = 2'd1,
		KIND_INFO  = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CODEC_UNKNOWN = 2'd0,
		CODEC_H264    = 2'd1,
		CODEC_H265    = 2'd2
	} codec_t;

	typedef enum logic [7:0] {
		PH_HUNT   = 8'b0000_0001,
		PH_INFO   = 8'b0000_0010,
		PH_VHDR   = 8'b0000_0100,
		PH_VEXTRA = 8'b0000_1000,
		PH_VPAY   = 8'b0001_0000,
		PH_AHDR   = 8'b0010_0000,
		PH_APAY   = 8'b0100_0000,
		PH_PAD    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic        key_frame;
		logic [1:0]  codec;
		logic [31:0] frame_microseconds;
		logic [31:0] wall_time;
		logic [31:0] picture_width;
		logic [31:0] picture_height;
	} result_t;
endpackage

/* design/cmsd_parser.sv */
// front part: magic hunt, header parsing and result forming, one byte per cycle while in_valid is high
`timescale 1ns / 1ps
module cmsd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	output logic                res_valid,
	output cmsd_pkg::result_t   res
);
	cmsd_pkg::phase_t phase_q;
	logic [7:0]  win_q [4];
	logic [2:0]  fill_q;
	logic [31:0] count_q, plen_q, xlen_q, usec_q, wall_q, width_q, height_q;
	logic        key_q, fwd_q, tag_q;
	logic [1:0]  codec_q;
	logic [4:0]  off_q;

	logic [7:0] w0, w1, w2, w3;
	logic       is_info, is_video, is_audio, win_full;
	logic [31:0] pos, count_dec, lenb, wall_nx;
	logic [1:0]  sh;

	assign w0 = win_q[1];
	assign w1 = win_q[2];
	assign w2 = win_q[3];
	assign w3 = in_byte;
	assign win_full = (fill_q >= 3'd3);
	assign is_info = w0 == "1" && w1 == "0" && w2 == "0" && (w3 == "1" || w3 == "2");
	assign is_video = w2 == "d" && w3 == "c" && w0 >= "0" && w0 <= "9" &&
		(w1 == "0" || w1 == "1");
	assign is_audio = w0 == "0" && (w1 == "5" || w1 == "1") && w2 == "w" && w3 == "b";
	assign pos = xlen_q - count_q;
	assign count_dec = count_q - 32'd1;
	assign sh = off_q[1:0];
	assign lenb = {24'd0, in_byte} << {sh, 3'b000};
	// wall time including the current extra header byte
	assign wall_nx = (pos < 32'd4 && xlen_q >= 32'd4) ?
		(wall_q | ({24'd0, in_byte} << {pos[1:0], 3'b000})) : wall_q;

	// padding to a multiple of 8 payload bytes
	function automatic logic [2:0] pad_of(input logic [31:0] len);
		return 3'(4'd8 - {1'b0, len[2:0]});
	endfunction

	function automatic cmsd_pkg::result_t mk(input logic [1:0] k, input logic [7:0] b,
		input logic l, input logic vid, input logic kf, input logic [1:0] cd,
		input logic [31:0] us, input logic [31:0] wt, input logic [31:0] wd,
		input logic [31:0] ht);
		cmsd_pkg::result_t r;
		r.kind = k;
		r.payload_byte = b;
		r.last_of_frame = l;
		r.key_frame = vid ? kf : 1'b0;
		r.codec = vid ? cd : 2'd0;
		r.frame_microseconds = vid ? us : 32'd0;
		r.wall_time = vid ? wt : 32'd0;
		r.picture_width = wd;
		r.picture_height = ht;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cmsd_pkg::PH_HUNT;
			fill_q <= '0;
			count_q <= '0; plen_q <= '0; xlen_q <= '0; usec_q <= '0; wall_q <= '0;
			width_q <= '0; height_q <= '0; key_q <= 1'b0; fwd_q <= 1'b0; tag_q <= 1'b0;
			codec_q <= '0; off_q <= '0; res_valid <= 1'b0;
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
			res <= '0;
		end else begin
			res_valid <= 1'b0;
			if (in_valid) begin
				unique case (phase_q)
					cmsd_pkg::PH_HUNT: begin
						win_q[0] <= win_q[1]; win_q[1] <= win_q[2];
						win_q[2] <= win_q[3]; win_q[3] <= in_byte;
						if (!win_full) fill_q <= fill_q + 3'd1;
						else if (is_info || is_video || is_audio) begin
							plen_q <= '0; xlen_q <= '0; off_q <= 5'd4;
							if (is_info) phase_q <= cmsd_pkg::PH_INFO;
							else if (is_video) begin
								key_q <= (w1 == "0"); codec_q <= '0; usec_q <= '0;
								wall_q <= '0; tag_q <= 1'b0; phase_q <= cmsd_pkg::PH_VHDR;
							end else begin
								fwd_q <= (w1 == "5"); phase_q <= cmsd_pkg::PH_AHDR;
							end
						end
					end
					cmsd_pkg::PH_INFO: begin
						if (off_q[4:2] == 3'd2) plen_q <= plen_q | lenb;
						else if (off_q[4:2] == 3'd3) xlen_q <= xlen_q | lenb;
						if (off_q == 5'd31) begin
							width_q <= plen_q; height_q <= xlen_q;
							phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0;
							res_valid <= 1'b1;
							res <= mk(cmsd_pkg::KIND_INFO, 8'd0, 1'b1, 1'b0, key_q, codec_q,
								usec_q, wall_q, plen_q, xlen_q);
						end else off_q <= off_q + 5'd1;
					end
					cmsd_pkg::PH_VHDR: begin
						if (off_q == 5'd4) tag_q <= (in_byte == "H");
						else if (off_q == 5'd5) tag_q <= tag_q && (in_byte == "2");
						else if (off_q == 5'd6) tag_q <= tag_q && (in_byte == "6");
						else if (off_q == 5'd7)
							codec_q <= tag_q ? ((in_byte == "5") ? cmsd_pkg::CODEC_H265 :
								cmsd_pkg::CODEC_H264) : cmsd_pkg::CODEC_UNKNOWN;
						else if (off_q[4:2] == 3'd2) plen_q <= plen_q | lenb;
						else if (off_q[4:2] == 3'd3) xlen_q <= xlen_q | lenb;
						else if (off_q[4:2] == 3'd4) usec_q <= usec_q | lenb;
						if (off_q == 5'd23) begin
							if (xlen_q != 0) begin
								count_q <= xlen_q; phase_q <= cmsd_pkg::PH_VEXTRA;
							end else if (plen_q == 0) begin
								phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0; res_valid <= 1'b1;
								res <= mk(cmsd_pkg::KIND_EMPTY, 8'd0, 1'b1, 1'b1, key_q,
									codec_q, usec_q, wall_q, width_q, height_q);
							end else begin
								count_q <= plen_q; phase_q <= cmsd_pkg::PH_VPAY;
							end
						end else off_q <= off_q + 5'd1;
					end
					cmsd_pkg::PH_VEXTRA: begin
						wall_q <= wall_nx;
						count_q <= count_dec;
						if (count_dec == 0) begin
							if (plen_q == 0) begin
								phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0; res_valid <= 1'b1;
								res <= mk(cmsd_pkg::KIND_EMPTY, 8'd0, 1'b1, 1'b1, key_q,
									codec_q, usec_q, wall_nx, width_q, height_q);
							end else begin
								count_q <= plen_q; phase_q <= cmsd_pkg::PH_VPAY;
							end
						end
					end
					cmsd_pkg::PH_VPAY, cmsd_pkg::PH_APAY: begin
						count_q <= count_dec;
						if (count_dec == 0) begin
							count_q <= {29'd0, pad_of(plen_q)};
							if (pad_of(plen_q) == 3'd0) begin
								phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0;
							end else phase_q <= cmsd_pkg::PH_PAD;
						end
						if (phase_q == cmsd_pkg::PH_VPAY) begin
							res_valid <= 1'b1;
							res <= mk(cmsd_pkg::KIND_VIDEO, in_byte, count_dec == 0, 1'b1,
								key_q, codec_q, usec_q, wall_q, width_q, height_q);
						end else if (fwd_q) begin
							res_valid <= 1'b1;
							res <= mk(cmsd_pkg::KIND_AUDIO, in_byte, count_dec == 0, 1'b0,
								key_q, codec_q, usec_q, wall_q, width_q, height_q);
						end
					end
					cmsd_pkg::PH_AHDR: begin
						if (off_q == 5'd4) plen_q <= plen_q | {24'd0, in_byte};
						else if (off_q == 5'd5) plen_q <= plen_q | {16'd0, in_byte, 8'd0};
						if (off_q == 5'd7) begin
							if (plen_q == 0) begin
								phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0;
							end else begin
								count_q <= plen_q; phase_q <= cmsd_pkg::PH_APAY;
							end
						end else off_q <= off_q + 5'd1;
					end
					cmsd_pkg::PH_PAD: begin
						if (count_q != 0) count_q <= count_dec;
						if (count_q <= 32'd1) begin
							phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0;
						end
					end
					default: begin
						phase_q <= cmsd_pkg::PH_HUNT; fill_q <= '0;
					end
				endcase
				// window restarts empty after a record
				if (phase_q != cmsd_pkg::PH_HUNT)
					for (int i = 0; i < 4; i++) win_q[i] <= '0;
			end
		end
	end
endmodule

/* design/cmsd_queue.sv */
// back part: result queue decoupling parser from output stall
`timescale 1ns / 1ps
module cmsd_queue #(
	parameter int unsigned DEPTH = cmsd_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  cmsd_pkg::result_t wr_data,
	output logic              almost_full,
	output logic              out_valid,
	input  logic              out_stall,
	output cmsd_pkg::result_t out_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	cmsd_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic rd;

	assign out_valid = (cnt_q != 0);
	assign out_data = mem_q[rp_q];
	assign rd = out_valid && !out_stall;
	// one slot kept for the word already inside the parser register
	assign almost_full = (cnt_q >= (AW+1)'(DEPTH - 1));

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd);
		end
	end
endmodule

/* design/camera_media_stream_deframer.sv */
// top level of the camera media stream deframer
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | stream_byte
//  out     | output    | out_valid/out_stall | kind .. picture_height
// one byte word per cycle while in_stall is low; a byte is registered in the
// parser, then queued, before out_valid. in_stall rises only when the queue
// nears full. reset returns to hunting with an empty window and empty queue.
`timescale 1ns / 1ps
module camera_media_stream_deframer #(
	parameter int unsigned QUEUE_DEPTH = cmsd_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last_of_frame,
	output logic        key_frame,
	output logic [1:0]  codec,
	output logic [31:0] frame_microseconds,
	output logic [31:0] wall_time,
	output logic [31:0] picture_width,
	output logic [31:0] picture_height
);
	logic res_valid, almost_full;
	cmsd_pkg::result_t res, q_out;

	cmsd_parser u_parser (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid && !in_stall),
		.in_byte(stream_byte), .res_valid(res_valid), .res(res)
	);

	cmsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(res_valid), .wr_data(res),
		.almost_full(almost_full), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(q_out)
	);

	assign in_stall = almost_full;
	assign kind = q_out.kind;
	assign payload_byte = q_out.payload_byte;
	assign last_of_frame = q_out.last_of_frame;
	assign key_frame = q_out.key_frame;
	assign codec = q_out.codec;
	assign frame_microseconds = q_out.frame_microseconds;
	assign wall_time = q_out.wall_time;
	assign picture_width = q_out.picture_width;
	assign picture_height = q_out.picture_height;
endmodule

/* design/cmsd_checker.sv */
// port-level checks for the camera media stream deframer
`timescale 1ns / 1ps
module cmsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] payload_byte,
	input logic       last_of_frame,
	input logic [1:0] codec
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte))
		else $error("stalled word changed");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == cmsd_pkg::KIND_INFO || kind == cmsd_pkg::KIND_EMPTY)
		|-> last_of_frame)
		else $error("single word without last");
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == cmsd_pkg::KIND_INFO || kind == cmsd_pkg::KIND_EMPTY)
		|-> payload_byte == 8'd0)
		else $error("marker word carries a byte");
	a_codec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> codec <= cmsd_pkg::CODEC_H265)
		else $error("bad codec");
endmodule

bind camera_media_stream_deframer cmsd_checker u_cmsd_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.kind(kind), .payload_byte(payload_byte), .last_of_frame(last_of_frame),
	.codec(codec)
);

/* tb/camera_media_stream_deframer_check.sv */
// checker: watches both channels, predicts results and compares them
`timescale 1ns / 1ps
module camera_media_stream_deframer_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  stream_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  payload_byte,
	input  logic        last_of_frame,
	input  logic        key_frame,
	input  logic [1:0]  codec,
	input  logic [31:0] frame_microseconds,
	input  logic [31:0] wall_time,
	input  logic [31:0] picture_width,
	input  logic [31:0] picture_height,
	output int          fail_count,
	output int          pending
);
	cmsd_pkg::result_t expected_words[$];

	logic [7:0]  win [4];
	int unsigned win_fill;
	cmsd_pkg::phase_t phase;
	logic [31:0] countdown, pay_len, extra_len, usec, wall, width, height;
	logic        key_flag, fwd_audio, tag_ok;
	logic [1:0]  codec_held;
	logic [4:0]  hdr_off;

	assign pending = expected_words.size();

	task automatic hunt_again();
		for (int i = 0; i < 4; i++) win[i] = 8'd0;
		win_fill = 0;
		phase = cmsd_pkg::PH_HUNT;
	endtask

	task automatic push_word(input cmsd_pkg::kind_t k, input logic [7:0] b, input logic l);
		cmsd_pkg::result_t r;
		logic vid;
		vid = (k == cmsd_pkg::KIND_VIDEO) || (k == cmsd_pkg::KIND_EMPTY);
		r.kind = k;
		r.payload_byte = b;
		r.last_of_frame = l;
		r.key_frame = vid ? key_flag : 1'b0;
		r.codec = vid ? codec_held : 2'd0;
		r.frame_microseconds = vid ? usec : 32'd0;
		r.wall_time = vid ? wall : 32'd0;
		r.picture_width = width;
		r.picture_height = height;
		expected_words.push_back(r);
	endtask

	task automatic after_payload();
		countdown = (32'd8 - (pay_len & 32'd7)) & 32'd7;
		if (countdown == 0) hunt_again();
		else phase = cmsd_pkg::PH_PAD;
	endtask

	task automatic start_video_payload();
		if (pay_len == 0) begin
			hunt_again();
			push_word(cmsd_pkg::KIND_EMPTY, 8'd0, 1'b1);
		end else begin
			countdown = pay_len;
			phase = cmsd_pkg::PH_VPAY;
		end
	endtask

	task automatic new_record();
		pay_len = 0;
		extra_len = 0;
		hdr_off = 5'd4;
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [31:0] pos;
		logic [4:0] off;
		off = hdr_off;
		case (phase)
			cmsd_pkg::PH_HUNT: begin
				win[0] = win[1]; win[1] = win[2]; win[2] = win[3]; win[3] = b;
				if (win_fill < 4) win_fill++;
				if (win_fill == 4) begin
					if (win[0] == "1" && win[1] == "0" && win[2] == "0"
							&& (win[3] == "1" || win[3] == "2")) begin
						new_record();
						phase = cmsd_pkg::PH_INFO;
					end else if (win[2] == "d" && win[3] == "c" && win[0] >= "0"
							&& win[0] <= "9" && (win[1] == "0" || win[1] == "1")) begin
						new_record();
						key_flag = (win[1] == "0");
						codec_held = cmsd_pkg::CODEC_UNKNOWN;
						usec = 0;
						wall = 0;
						tag_ok = 1'b0;
						phase = cmsd_pkg::PH_VHDR;
					end else if (win[0] == "0" && (win[1] == "5" || win[1] == "1")
							&& win[2] == "w" && win[3] == "b") begin
						new_record();
						fwd_audio = (win[1] == "5");
						phase = cmsd_pkg::PH_AHDR;
					end
				end
			end
			cmsd_pkg::PH_INFO: begin
				if (off >= 8 && off <= 11) pay_len |= 32'(b) << (8 * (off - 8));
				else if (off >= 12 && off <= 15) extra_len |= 32'(b) << (8 * (off - 12));
				if (off == 31) begin
					width = pay_len;
					height = extra_len;
					hunt_again();
					push_word(cmsd_pkg::KIND_INFO, 8'd0, 1'b1);
				end else hdr_off = off + 1;
			end
			cmsd_pkg::PH_VHDR: begin
				if (off == 4) tag_ok = (b == "H");
				else if (off == 5) tag_ok = tag_ok && (b == "2");
				else if (off == 6) tag_ok = tag_ok && (b == "6");
				else if (off == 7)
					codec_held = tag_ok ? ((b == "5") ? cmsd_pkg::CODEC_H265 :
						cmsd_pkg::CODEC_H264) : cmsd_pkg::CODEC_UNKNOWN;
				else if (off >= 8 && off <= 11) pay_len |= 32'(b) << (8 * (off - 8));
				else if (off >= 12 && off <= 15) extra_len |= 32'(b) << (8 * (off - 12));
				else if (off >= 16 && off <= 19) usec |= 32'(b) << (8 * (off - 16));
				if (off >= 23) begin
					if (extra_len != 0) begin
						countdown = extra_len;
						phase = cmsd_pkg::PH_VEXTRA;
					end else start_video_payload();
				end else hdr_off = off + 1;
			end
			cmsd_pkg::PH_VEXTRA: begin
				pos = extra_len - countdown;
				if (pos < 4 && extra_len >= 4) wall |= 32'(b) << (8 * pos);
				countdown--;
				if (countdown == 0) start_video_payload();
			end
			cmsd_pkg::PH_VPAY: begin
				countdown--;
				if (countdown == 0) begin
					after_payload();
					push_word(cmsd_pkg::KIND_VIDEO, b, 1'b1);
				end else push_word(cmsd_pkg::KIND_VIDEO, b, 1'b0);
			end
			cmsd_pkg::PH_AHDR: begin
				if (off == 4) pay_len |= 32'(b);
				else if (off == 5) pay_len |= 32'(b) << 8;
				if (off >= 7) begin
					if (pay_len == 0) hunt_again();
					else begin
						countdown = pay_len;
						phase = cmsd_pkg::PH_APAY;
					end
				end else hdr_off = off + 1;
			end
			cmsd_pkg::PH_APAY: begin
				countdown--;
				if (countdown == 0) begin
					after_payload();
					if (fwd_audio) push_word(cmsd_pkg::KIND_AUDIO, b, 1'b1);
				end else if (fwd_audio) push_word(cmsd_pkg::KIND_AUDIO, b, 1'b0);
			end
			cmsd_pkg::PH_PAD: begin
				if (countdown > 0) countdown--;
				if (countdown == 0) hunt_again();
			end
			default: hunt_again();
		endcase
	endtask

	task automatic compare_word();
		cmsd_pkg::result_t got, want;
		got = '{kind, payload_byte, last_of_frame, key_frame, codec,
			frame_microseconds, wall_time, picture_width, picture_height};
		if (expected_words.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected word: %p", got);
			return;
		end
		want = expected_words.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch: expected %p actual %p", want, got);
		end
	endtask

	initial begin
		fail_count = 0;
		hunt_again();
		countdown = 0; pay_len = 0; extra_len = 0; usec = 0; wall = 0;
		width = 0; height = 0; key_flag = 0; fwd_audio = 0; tag_ok = 0;
		codec_held = 0; hdr_off = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) compare_word();
			if (in_valid && !in_stall) predict_byte(stream_byte);
		end
	end
endmodule

/* tb/camera_media_stream_deframer_test.sv */
// testbench top: clock, reset, byte stream stimulus and verdict
`timescale 1ns / 1ps
module camera_media_stream_deframer_test;
	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [7:0]  stream_byte;
	logic [1:0]  kind, codec;
	logic [7:0]  payload_byte;
	logic        last_of_frame, key_frame;
	logic [31:0] frame_microseconds, wall_time, picture_width, picture_height;
	int          fail_count, pending;
	int          cycles;
	int          send_idle_pct, stall_pct;
	bit          hold_off;
	int          byte_total;
	logic [7:0]  rec[$];

	camera_media_stream_deframer i_dut (.*);

	camera_media_stream_deframer_check i_check (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver stall, with a long hold-off on request
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off) out_stall <= 1'b1;
			else out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		byte_total++;
	endtask

	task automatic flush_rec();
		while (rec.size() > 0) send_byte(rec.pop_front());
		in_valid <= 1'b0;
	endtask

	task automatic add_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) rec.push_back(w[8*i +: 8]);
	endtask

	task automatic build_info(input logic [31:0] w, input logic [31:0] h);
		rec.push_back("1"); rec.push_back("0"); rec.push_back("0");
		rec.push_back($urandom_range(1) ? "1" : "2");
		add_word($urandom); add_word(w); add_word(h);
		for (int i = 16; i < 32; i++) rec.push_back(8'($urandom));
	endtask

	task automatic build_video(input logic [31:0] len, input logic [31:0] extra,
			input int tag_sel);
		logic [7:0] t3;
		rec.push_back(8'("0") + 8'($urandom_range(9)));
		rec.push_back($urandom_range(1) ? "0" : "1");
		rec.push_back("d"); rec.push_back("c");
		t3 = (tag_sel == 0) ? "5" : (tag_sel == 1) ? "4" : 8'($urandom);
		if (tag_sel == 3) rec.push_back("X"); else rec.push_back("H");
		rec.push_back(tag_sel == 4 ? "3" : "2");
		rec.push_back("6");
		rec.push_back(t3);
		add_word(len); add_word(extra); add_word($urandom);
		for (int i = 20; i < 24; i++) rec.push_back(8'($urandom));
		for (int i = 0; i < extra; i++) rec.push_back(8'($urandom));
		for (int i = 0; i < len; i++) rec.push_back(8'($urandom));
		for (int i = 0; i < ((8 - (len & 7)) & 7); i++) rec.push_back(8'($urandom));
	endtask

	task automatic build_audio(input bit aac, input int len);
		rec.push_back("0"); rec.push_back(aac ? "5" : "1");
		rec.push_back("w"); rec.push_back("b");
		rec.push_back(len[7:0]); rec.push_back(len[15:8]);
		rec.push_back(8'($urandom)); rec.push_back(8'($urandom));
		for (int i = 0; i < len; i++) rec.push_back(8'($urandom));
		for (int i = 0; i < ((8 - (len & 7)) & 7); i++) rec.push_back(8'($urandom));
	endtask

	task automatic random_record();
		int r;
		r = $urandom_range(99);
		if (r < 15) build_info($urandom, $urandom);
		else if (r < 60) build_video($urandom_range(12), $urandom_range(6),
			$urandom_range(5));
		else if (r < 80) build_audio($urandom_range(1), $urandom_range(12));
		else for (int i = 0; i < $urandom_range(6); i++) rec.push_back(8'($urandom));
		// drop the last byte when random junk was queued and more than six bytes wait
		if (r >= 95 && rec.size() > 6) void'(rec.pop_back());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		arst_n = 0; in_valid = 0; stream_byte = 0;
		send_idle_pct = 0; stall_pct = 0; hold_off = 0; byte_total = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every record type, codec tags, empty frames
		rec.push_back(8'hff); rec.push_back(8'h00);
		build_info(32'hffff_ffff, 32'h0000_0000);
		build_video(0, 0, 0);
		build_video(1, 4, 1);
		build_video(8, 3, 3);
		build_video(9, 5, 4);
		build_audio(1, 3);
		build_audio(0, 9);
		build_audio(1, 0);
		rec.push_back("9"); rec.push_back("2"); rec.push_back("d"); rec.push_back("c");
		build_info(32'h0000_0000, 32'hffff_ffff);
		flush_rec();
		drain();

		// long receiver hold-off while bytes keep coming
		hold_off = 1;
		fork
			begin
				build_video(40, 0, 0);
				flush_rec();
			end
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 73) : 0;
			stall_pct = (ph == 2) ? 73 : (ph == 3) ? 16 : 0;
			while (byte_total < 430 * (ph + 1) + 100) begin
				random_record();
				flush_rec();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
